@@ sv/assert_macros.svh @@
// Concurrent assertion macros used by the RTL module direct_line_rasterizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ sv/dlr_pkg.sv @@
// Types and constants of the line rasterizer.
package dlr_pkg;

  localparam int COORD_BITS = 6;
  // remainder spans [-2d, 4d) with d < 2^COORD_BITS
  localparam int ERR_BITS = COORD_BITS + 3;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic signed [COORD_BITS:0] delta_t;
  typedef logic signed [ERR_BITS-1:0] err_t;

  typedef enum logic [1:0] {
    MODE_VERT,
    MODE_HORIZ,
    MODE_SHALLOW,
    MODE_STEEP
  } line_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN
  } state_t;

endpackage

@@ sv/dlr_seg_if.sv @@
// Segment input channel: two endpoints per transaction.
interface dlr_seg_if import dlr_pkg::*;;
  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;

  modport source (output valid, output start_x, output start_y, output end_x, output end_y,
                  input ready);
  modport sink (input valid, input start_x, input start_y, input end_x, input end_y,
                output ready);
endinterface

@@ sv/dlr_pix_if.sv @@
// Pixel output channel: one pixel per transaction.
interface dlr_pix_if import dlr_pkg::*;;
  logic   valid;
  logic   ready;
  coord_t pixel_x;
  coord_t pixel_y;
  logic   last_pixel;

  modport source (output valid, output pixel_x, output pixel_y, output last_pixel,
                  input ready);
  modport sink (input valid, input pixel_x, input pixel_y, input last_pixel,
                output ready);
endinterface

@@ sv/direct_line_rasterizer.sv @@
// Line rasterizer top level: steps the major axis, rounds the minor axis.
//
//   channel   | dir | handshake     | payload
//   in_seg    | in  | valid / ready | start_x, start_y, end_x, end_y
//   out_pix   | out | valid / ready | pixel_x, pixel_y, last_pixel
//
// A segment is accepted in ST_IDLE and set up in ST_SETUP; ST_RUN then emits its d + 1 pixels,
// one pixel per cycle while out_pix is ready, with d = larger of |dx|, |dy|.
// The pixel rate is set by the single remainder add / compare / correct unit.
// Reset (rst_n low, synchronous) returns to idle and drops any line in flight.
// A stall on out_pix holds the current pixel; in_seg is not ready until the
// last pixel of the line is taken.
`include "assert_macros.svh"

module direct_line_rasterizer import dlr_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  dlr_seg_if.sink   in_seg,
  dlr_pix_if.source out_pix
);

  state_t     state_r, state_nxt;
  coord_t     x0_r, y0_r, x1_r, y1_r;
  line_mode_t mode_r;
  coord_t     major_r, minor_r, count_r, dmaj_r;
  delta_t     dmin_r;
  err_t       err_r;

  logic       in_hs, out_hs, last;

  // setup decode
  delta_t     dx, dy;
  coord_t     adx, ady;
  logic       x_fwd, y_fwd;
  line_mode_t mode_s;
  coord_t     bmaj_s, bmin_s, dmaj_s;
  delta_t     dmin_s;

  // shared remainder unit
  err_t       inc, twod, sum, err_nxt;
  coord_t     minor_nxt;

  assign in_hs  = in_seg.valid && in_seg.ready;
  assign out_hs = out_pix.valid && out_pix.ready;
  assign last   = (count_r == '0);

  always_comb begin
    dx    = delta_t'({1'b0, x1_r}) - delta_t'({1'b0, x0_r});
    dy    = delta_t'({1'b0, y1_r}) - delta_t'({1'b0, y0_r});
    adx   = dx[COORD_BITS] ? coord_t'(-dx) : coord_t'(dx);
    ady   = dy[COORD_BITS] ? coord_t'(-dy) : coord_t'(dy);
    x_fwd = (x0_r < x1_r);
    y_fwd = (y0_r < y1_r);
    if (dx == '0) begin
      mode_s = MODE_VERT;
    end else if (dy == '0) begin
      mode_s = MODE_HORIZ;
    end else if (ady <= adx) begin
      mode_s = MODE_SHALLOW;
    end else begin
      mode_s = MODE_STEEP;
    end
    case (mode_s)
      MODE_HORIZ: begin
        bmaj_s = x_fwd ? x0_r : x1_r;
        bmin_s = y0_r;
        dmaj_s = adx;
        dmin_s = '0;
      end
      MODE_SHALLOW: begin
        bmaj_s = x_fwd ? x0_r : x1_r;
        bmin_s = x_fwd ? y0_r : y1_r;
        dmaj_s = adx;
        dmin_s = x_fwd ? dy : -dy;
      end
      MODE_STEEP: begin
        bmaj_s = y_fwd ? y0_r : y1_r;
        bmin_s = y_fwd ? x0_r : x1_r;
        dmaj_s = ady;
        dmin_s = y_fwd ? dx : -dx;
      end
      default: begin
        bmaj_s = y_fwd ? y0_r : y1_r;
        bmin_s = x0_r;
        dmaj_s = ady;
        dmin_s = '0;
      end
    endcase
  end

  // Remainder of (2*dmin*k + d) over 2d stays in [0, 2d); one correction per step.
  always_comb begin
    inc       = err_t'(dmin_r) <<< 1;
    twod      = err_t'({1'b0, dmaj_r, 1'b0});
    sum       = err_r + inc;
    err_nxt   = sum;
    minor_nxt = minor_r;
    if (!dmin_r[COORD_BITS] && (dmin_r != '0) && (sum >= twod)) begin
      err_nxt   = sum - twod;
      minor_nxt = minor_r + coord_t'(1);
    end else if (dmin_r[COORD_BITS] && (sum < 0)) begin
      err_nxt   = sum + twod;
      minor_nxt = minor_r - coord_t'(1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_hs) state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = ST_RUN;
      ST_RUN:   if (out_hs && last) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_seg.ready  = 1'b0;
    out_pix.valid = 1'b0;
    case (state_r)
      ST_IDLE: in_seg.ready  = 1'b1;
      ST_RUN:  out_pix.valid = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    if ((mode_r == MODE_VERT) || (mode_r == MODE_STEEP)) begin
      out_pix.pixel_x = minor_r;
      out_pix.pixel_y = major_r;
    end else begin
      out_pix.pixel_x = major_r;
      out_pix.pixel_y = minor_r;
    end
    out_pix.last_pixel = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_hs) begin
      x0_r <= in_seg.start_x;
      y0_r <= in_seg.start_y;
      x1_r <= in_seg.end_x;
      y1_r <= in_seg.end_y;
    end
    if (state_r == ST_SETUP) begin
      mode_r  <= mode_s;
      major_r <= bmaj_s;
      minor_r <= bmin_s;
      count_r <= dmaj_s;
      dmaj_r  <= dmaj_s;
      dmin_r  <= dmin_s;
      err_r   <= err_t'({1'b0, dmaj_s});
    end else if (out_hs) begin
      // advance to the next pixel on the major axis
      major_r <= major_r + coord_t'(1);
      minor_r <= minor_nxt;
      count_r <= count_r - coord_t'(1);
      err_r   <= err_nxt;
    end
  end

  `ASSERT_IMP(a_no_input_while_drawing, clk, rst_n, out_pix.valid, !in_seg.ready)
  `ASSERT_NXT(a_last_frees_input, clk, rst_n, out_hs && last, in_seg.ready)
  `ASSERT_NXT(a_line_continues, clk, rst_n, out_hs && !last, out_pix.valid)
  `ASSERT_NXT(a_major_steps, clk, rst_n, out_hs && !last,
              major_r == $past(major_r) + coord_t'(1))
  `ASSERT_IMP(a_remainder_range, clk, rst_n, out_pix.valid,
              (err_r >= 0) && ((dmaj_r == '0) || (err_r < twod)))

endmodule

@@ tb/sv/testbench.sv @@
// Testbench for direct_line_rasterizer: random and directed segments checked pixel by pixel.
`timescale 1ns / 1ps

module testbench;
  import dlr_pkg::*;

  localparam int IDLE_PERCENT = 37;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 70;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  logic clk;
  logic rst_n;

  dlr_seg_if seg ();
  dlr_pix_if pix ();

  direct_line_rasterizer uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_seg  (seg),
    .out_pix (pix)
  );

  pixel_t expected_pixels[$];
  int     mismatch_count;
  bit     full_rate;
  bit     hold_request;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("direct_line_rasterizer: mismatch");
    $finish;
  end

  // Work out every pixel of one segment, in the order the block emits them.
  function automatic void plot_segment(input coord_t sx, input coord_t sy,
                                       input coord_t ex, input coord_t ey);
    int         dx, dy, adx, ady;
    int         base_major, base_minor, span, slope_num, minor, num;
    line_mode_t mode;
    pixel_t     p;
    dx  = int'(ex) - int'(sx);
    dy  = int'(ey) - int'(sy);
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    if (dx == 0) begin
      mode       = MODE_VERT;
      base_major = sy < ey ? int'(sy) : int'(ey);
      base_minor = int'(sx);
      span       = ady;
      slope_num  = 0;
    end else if (dy == 0) begin
      mode       = MODE_HORIZ;
      base_major = sx < ex ? int'(sx) : int'(ex);
      base_minor = int'(sy);
      span       = adx;
      slope_num  = 0;
    end else if (ady <= adx) begin
      mode       = MODE_SHALLOW;
      base_major = sx < ex ? int'(sx) : int'(ex);
      base_minor = sx < ex ? int'(sy) : int'(ey);
      span       = adx;
      slope_num  = sx < ex ? dy : -dy;
    end else begin
      mode       = MODE_STEEP;
      base_major = sy < ey ? int'(sy) : int'(ey);
      base_minor = sy < ey ? int'(sx) : int'(ex);
      span       = ady;
      slope_num  = sy < ey ? dx : -dx;
    end
    for (int k = 0; k <= span; k++) begin
      if (span == 0) begin
        minor = base_minor;
      end else begin
        // round half toward the larger coordinate
        num   = 2 * (base_minor * span + slope_num * k) + span;
        minor = num < 0 ? 0 : num / (2 * span);
      end
      if (mode == MODE_VERT || mode == MODE_STEEP) begin
        p.x = coord_t'(minor);
        p.y = coord_t'(base_major + k);
      end else begin
        p.x = coord_t'(base_major + k);
        p.y = coord_t'(minor);
      end
      p.last = (k == span);
      expected_pixels.push_back(p);
    end
  endfunction

  // Offer one segment; valid stays high afterwards so back-to-back items need no gap.
  task automatic offer_segment(input coord_t sx, input coord_t sy,
                               input coord_t ex, input coord_t ey);
    while (!full_rate && $urandom_range(99) < IDLE_PERCENT) begin
      seg.valid <= 1'b0;
      @(posedge clk);
    end
    seg.valid   <= 1'b1;
    seg.start_x <= sx;
    seg.start_y <= sy;
    seg.end_x   <= ex;
    seg.end_y   <= ey;
    @(posedge clk);
    while (!seg.ready) @(posedge clk);
    plot_segment(sx, sy, ex, ey);
  endtask

  task automatic park_sender();
    seg.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_for_pixels();
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic random_line(output coord_t sx, output coord_t sy,
                             output coord_t ex, output coord_t ey);
    int len;
    sx = coord_t'($urandom);
    sy = coord_t'($urandom);
    ex = coord_t'($urandom);
    ey = coord_t'($urandom);
    case ($urandom_range(9))
      0: ex = sx;
      1: ey = sy;
      2: begin
        // exact diagonal, either direction
        len = $urandom_range(63 - int'(sx > sy ? sx : sy));
        ex  = coord_t'(int'(sx) + len);
        ey  = ($urandom_range(1) != 0) ? coord_t'(int'(sy) + len) : sy;
        sy  = (ey == sy) ? coord_t'(int'(sy) + len) : sy;
      end
      3, 4: begin
        ex = sx ^ coord_t'($urandom_range(7));
        ey = sy ^ coord_t'($urandom_range(7));
      end
      default: ;
    endcase
  endtask

  task automatic test_directed();
    offer_segment(6'd0, 6'd0, 6'd0, 6'd0);
    offer_segment(6'd63, 6'd63, 6'd63, 6'd63);
    offer_segment(6'd0, 6'd63, 6'd0, 6'd0);
    offer_segment(6'd63, 6'd0, 6'd63, 6'd63);
    offer_segment(6'd63, 6'd0, 6'd0, 6'd0);
    offer_segment(6'd0, 6'd63, 6'd63, 6'd63);
    offer_segment(6'd0, 6'd0, 6'd63, 6'd63);
    offer_segment(6'd63, 6'd0, 6'd0, 6'd63);
    // half-way ties, rising and falling, both axes; then long and diagonal lines
    offer_segment(6'd0, 6'd0, 6'd2, 6'd1);
    offer_segment(6'd2, 6'd0, 6'd0, 6'd1);
    offer_segment(6'd0, 6'd0, 6'd1, 6'd2);
    offer_segment(6'd1, 6'd0, 6'd0, 6'd2);
    offer_segment(6'd63, 6'd10, 6'd0, 6'd11);
    offer_segment(6'd5, 6'd63, 6'd6, 6'd0);
    offer_segment(6'd0, 6'd0, 6'd63, 6'd62);
    offer_segment(6'd0, 6'd63, 6'd62, 6'd0);
    offer_segment(6'd42, 6'd21, 6'd21, 6'd42);
    park_sender();
  endtask

  task automatic test_random_lines(input int count);
    coord_t sx, sy, ex, ey;
    repeat (count) begin
      random_line(sx, sy, ex, ey);
      offer_segment(sx, sy, ex, ey);
    end
    park_sender();
  endtask

  task automatic test_full_rate(input int count);
    full_rate = 1'b1;
    test_random_lines(count);
    wait_for_pixels();
    full_rate = 1'b0;
  endtask

  // Hold off the pixel side while segments keep coming, so the input stalls.
  task automatic test_backpressure(input int count);
    hold_request = 1'b1;
    test_random_lines(count);
  endtask

  task automatic test_drain_pause(input int groups, input int per_group);
    repeat (groups) begin
      test_random_lines(per_group);
      wait_for_pixels();
    end
  endtask

  // Pixel side: random stalls (none in full-rate mode), a long hold-off on request.
  initial begin
    pix.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        pix.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        pix.ready <= full_rate || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Compare every pixel transaction with the oldest expected pixel.
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && pix.valid && pix.ready) begin
      if (expected_pixels.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected pixel, expected none, actual x=%0d y=%0d last=%0b",
                 $time, pix.pixel_x, pix.pixel_y, pix.last_pixel);
      end else begin
        want = expected_pixels.pop_front();
        if (pix.pixel_x !== want.x) begin
          mismatch_count++;
          $display("%0t: pixel_x expected %0d actual %0d", $time, want.x, pix.pixel_x);
        end
        if (pix.pixel_y !== want.y) begin
          mismatch_count++;
          $display("%0t: pixel_y expected %0d actual %0d", $time, want.y, pix.pixel_y);
        end
        if (pix.last_pixel !== want.last) begin
          mismatch_count++;
          $display("%0t: last_pixel expected %0b actual %0b", $time, want.last,
                   pix.last_pixel);
        end
      end
    end
  end

  initial begin
    mismatch_count = 0;
    full_rate      = 1'b0;
    hold_request   = 1'b0;
    rst_n       <= 1'b0;
    seg.valid   <= 1'b0;
    seg.start_x <= '0;
    seg.start_y <= '0;
    seg.end_x   <= '0;
    seg.end_y   <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_lines(180);
    test_full_rate(60);
    test_backpressure(40);
    test_drain_pause(4, 10);

    wait_for_pixels();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("direct_line_rasterizer: match");
    end else begin
      $display("direct_line_rasterizer: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/dlr_pkg.sv
sv/dlr_seg_if.sv
sv/dlr_pix_if.sv
sv/direct_line_rasterizer.sv
tb/sv/testbench.sv
